FILE: rtl/kse_pkg.sv
package kse_pkg;

  // payload widths of the channels
  localparam int unsigned RAW_W      = 17;
  localparam int unsigned MAP_KEY_W  = 5;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned ARG_W      = 7;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MAX_KEYS   = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned INTERVAL_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_EN    = 2'd2;

  localparam logic [PERIOD_W-1:0]  TICK_PERIOD_RST = 8'd4;

  // input operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_KEY_ON  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KEY_OFF = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SW_ON   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SW_OFF  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;

  // default code of an unwritten key is a switch with the key number
  localparam logic [CODE_W-1:0] CODE_SWITCH = 8'h80;

endpackage

FILE: rtl/kse_if.sv
interface kse_in_if;
  import kse_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [RAW_W-1:0]     raw_sample;
  logic [MAP_KEY_W-1:0] map_key;
  logic [CODE_W-1:0]    map_code;

  modport source (output valid, operation, raw_sample, map_key, map_code, input ready);
  modport sink   (input valid, operation, raw_sample, map_key, map_code, output ready);
endinterface

interface kse_out_if;
  import kse_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ARG_W-1:0]  event_arg;
  logic              last_of_tick;

  modport source (output valid, event_kind, event_arg, last_of_tick, input ready);
  modport sink   (input valid, event_kind, event_arg, last_of_tick, output ready);
endinterface

FILE: rtl/key_scan_debounce_event_encoder_core.sv
// Key scanner core: debounces a raw key sample per scan tick and turns
// stable level changes into a stream of key / switch events, plus one
// repeating timeout event.
// in_ch (valid/ready): operation 0 is a scan tick with raw_sample
// (0 = pressed), operation 1 writes code map_code for key map_key.
// out_ch (valid/ready): event_kind, event_arg, last_of_tick; the final
// event of a tick carries last_of_tick = 1. A tick that changes nothing
// and fires no timeout gives no event at all.
// cfg_we/cfg_index/cfg_wdata: register 0 tick period, 1 timer interval,
// 2 timer enable; write only while the block is idle.
// Walk: a tick walks the on keys then the off keys, one key slot per cycle
// through the code table RAM while no key event waits in the walk stage,
// stopping after the last changed key. The first key event passes the
// change masks, the RAM read stage and the output register; the walk
// uses the single RAM read port.
// Reset: code table reads 0x80 + key until written, the first tick only
// loads the filter, timer and registers return to defaults.
// A stalled receiver holds the output register and freezes the walk;
// in_ch.ready stays low until all events of the tick are in the register.
module key_scan_debounce_event_encoder_core #(
  parameter int unsigned KEY_COUNT = 17
) (
  input  logic                               clk,
  input  logic                               rst_n,
  kse_in_if.sink                             in_ch,
  kse_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [kse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kse_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import kse_pkg::*;

  localparam int unsigned KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned SW = $clog2(2 * KEY_COUNT + 1);

  // configuration registers
  logic [PERIOD_W-1:0]   tick_period_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic                  tmr_en_r;

  // filter and timer state
  logic                  primed_r;
  logic [KEY_COUNT-1:0]  prev_r;
  logic [KEY_COUNT-1:0]  stable_r;
  logic [TIME_W-1:0]     diff_r, diff_nxt;
  logic                  timer_chk_r;
  logic                  tmo_pend_r;

  // pending change masks and walk index
  logic [KEY_COUNT-1:0]  down_r, down_nxt;
  logic [KEY_COUNT-1:0]  up_r, up_nxt;
  logic [SW-1:0]         idx_r;

  // stage after the RAM read
  logic                  b_valid_r;
  logic                  b_hit_r;
  logic                  b_on_r;
  logic [KW-1:0]         b_key_r;

  logic [KEY_COUNT-1:0]  map_valid_r;

  // output register
  logic                  out_valid_r;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [ARG_W-1:0]      out_arg_r, out_arg_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  busy;
  logic                  in_acc;
  logic                  tick_acc;
  logic                  map_acc;
  logic                  map_in_range;
  logic [MAX_KEYS-1:0]   raw_ext;
  logic [KEY_COUNT-1:0]  sample;
  logic [KEY_COUNT-1:0]  changed;
  logic                  sweeping;
  logic                  out_free;
  logic                  b_emit;
  logic                  tmo_emit;
  logic                  out_load;
  logic                  advance;
  logic                  phase_off;
  logic [SW-1:0]         key_wide;
  logic [KW-1:0]         a_key;
  logic                  a_bit;
  logic                  ram_re;
  logic                  ram_we;
  logic [CODE_W-1:0]     ram_rdata;
  logic [CODE_W-1:0]     code;

  // handshake and input decode
  assign sweeping     = (|down_r) | (|up_r);
  assign busy         = timer_chk_r | tmo_pend_r | sweeping | (b_valid_r & b_hit_r);
  assign in_ch.ready  = ~busy;
  assign in_acc       = in_ch.valid & ~busy;
  assign tick_acc     = in_acc & (in_ch.operation == OP_TICK);
  assign map_acc      = in_acc & (in_ch.operation == OP_MAP);
  assign map_in_range = {1'b0, in_ch.map_key} < (MAP_KEY_W + 1)'(KEY_COUNT);
  assign raw_ext      = {(MAX_KEYS - RAW_W)'(0), in_ch.raw_sample};
  assign sample       = raw_ext[KEY_COUNT-1:0];
  assign changed      = stable_r ^ sample;

  // output arbitration: timeout goes first
  assign out_free  = ~out_valid_r | out_ch.ready;
  assign tmo_emit  = tmo_pend_r & out_free;
  assign b_emit    = b_valid_r & b_hit_r & ~timer_chk_r & ~tmo_pend_r & out_free;
  assign out_load  = tmo_emit | b_emit;
  assign advance   = ~(b_valid_r & b_hit_r) | b_emit;

  // walk position: on keys, then off keys
  assign phase_off = idx_r >= SW'(KEY_COUNT);
  assign key_wide  = phase_off ? (idx_r - SW'(KEY_COUNT)) : idx_r;
  assign a_key     = key_wide[KW-1:0];
  assign a_bit     = phase_off ? up_r[a_key] : down_r[a_key];
  assign ram_re    = advance & sweeping;
  assign ram_we    = map_acc & map_in_range;

  kse_ram #(
    .WIDTH (CODE_W),
    .DEPTH (KEY_COUNT)
  ) u_code_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.map_key[KW-1:0]),
    .wdata (in_ch.map_code),
    .re    (ram_re),
    .raddr (a_key),
    .rdata (ram_rdata)
  );

  // unwritten keys read as a switch with their own number
  assign code = map_valid_r[b_key_r] ? ram_rdata : (CODE_SWITCH + CODE_W'(b_key_r));

  // next event payload
  always_comb begin
    out_kind_nxt = out_kind_r;
    out_arg_nxt  = out_arg_r;
    out_last_nxt = out_last_r;
    if (tmo_emit) begin
      out_kind_nxt = KIND_TIMEOUT;
      out_arg_nxt  = ARG_W'(0);
      out_last_nxt = ~sweeping & ~(b_valid_r & b_hit_r);
    end else if (b_emit) begin
      if (code[CODE_W-1]) begin
        out_kind_nxt = b_on_r ? KIND_SW_ON : KIND_SW_OFF;
      end else begin
        out_kind_nxt = b_on_r ? KIND_KEY_ON : KIND_KEY_OFF;
      end
      out_arg_nxt  = code[ARG_W-1:0];
      out_last_nxt = ~sweeping;
    end
  end

  // change masks: loaded by a stable tick, cleared bit by bit by the walk
  always_comb begin
    down_nxt = down_r;
    up_nxt   = up_r;
    if (tick_acc && primed_r && (prev_r == sample)) begin
      down_nxt = changed & ~sample;
      up_nxt   = changed & sample;
    end else if (ram_re) begin
      if (phase_off) begin
        up_nxt[a_key] = 1'b0;
      end else begin
        down_nxt[a_key] = 1'b0;
      end
    end
  end

  // timer difference: due time minus current time
  always_comb begin
    diff_nxt = diff_r;
    if (tick_acc && primed_r) begin
      diff_nxt = diff_r - TIME_W'(tick_period_r);
    end else if (timer_chk_r && tmr_en_r && ((diff_r == '0) || diff_r[TIME_W-1])) begin
      diff_nxt = diff_r + TIME_W'(interval_r);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
      interval_r    <= '0;
      tmr_en_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_PERIOD: tick_period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_INTERVAL:    interval_r    <= cfg_wdata[INTERVAL_W-1:0];
        REG_TIMER_EN:    tmr_en_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // filter, timer and walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      prev_r      <= '0;
      stable_r    <= '0;
      diff_r      <= '0;
      timer_chk_r <= 1'b0;
      tmo_pend_r  <= 1'b0;
      down_r      <= '0;
      up_r        <= '0;
      idx_r       <= '0;
      b_valid_r   <= 1'b0;
      b_hit_r     <= 1'b0;
      map_valid_r <= '0;
    end else begin
      down_r <= down_nxt;
      up_r   <= up_nxt;
      diff_r <= diff_nxt;

      if (tick_acc) begin
        prev_r   <= sample;
        primed_r <= 1'b1;
        idx_r    <= '0;
        if (!primed_r || (prev_r == sample)) begin
          stable_r <= sample;
        end
      end else if (ram_re) begin
        idx_r <= idx_r + SW'(1);
      end

      // timeout decision in the cycle after the clock advance
      timer_chk_r <= tick_acc & primed_r;
      if (timer_chk_r && tmr_en_r && ((diff_r == '0) || diff_r[TIME_W-1])) begin
        tmo_pend_r <= 1'b1;
      end else if (tmo_emit) begin
        tmo_pend_r <= 1'b0;
      end

      if (advance) begin
        b_valid_r <= sweeping;
        b_hit_r   <= sweeping & a_bit;
      end

      if (ram_we) begin
        map_valid_r[in_ch.map_key[KW-1:0]] <= 1'b1;
      end
    end
  end

  // walk stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      b_on_r  <= ~phase_off;
      b_key_r <= a_key;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_arg_r  <= out_arg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.event_arg    = out_arg_r;
  assign out_ch.last_of_tick = out_last_r;

`ifndef SYNTH
  // a pending event in the walk stage keeps new items out
  a_hit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_hit_r) |-> !in_ch.ready)
    else $error("item accepted while a key event is pending");

  // the code table is never written during a walk read
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("code table written during a read");

  // no key event may pass the undecided timeout
  a_timeout_first: assert property (@(posedge clk) disable iff (!rst_n)
    timer_chk_r |-> !out_load)
    else $error("event emitted before timeout decision");

  // after the last event of a tick the block is idle
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> !busy)
    else $error("work left after last event of tick");
`endif

endmodule

FILE: rtl/kse_ram.sv
module kse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 17
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
